// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the row window checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== rtl/lrwb_pkg.sv =====
// ---------------------------------------------------------------------------
// lrwb_pkg
// Types and constants shared by the lazy row window buffer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package lrwb_pkg;

   localparam int MaxResults = 63;
   localparam int WindowWidth = 6;

   localparam logic CMD_DATA     = 1'b0;
   localparam logic CMD_ACTIVATE = 1'b1;

   localparam logic MARK_PLUS  = 1'b0;
   localparam logic MARK_MINUS = 1'b1;

   typedef struct packed {
      logic        command;
      logic [31:0] timestamp;
      logic        master_tag;
      logic [31:0] payload;
   } req_type;

   typedef struct packed {
      logic        mark;
      logic [31:0] out_time;
      logic        out_tag;
      logic [31:0] out_payload;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] time_stamp;
      logic        tag;
      logic [31:0] payload;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLUS,
      ST_MINUS,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      SRC_PLUS,
      SRC_MINUS,
      SRC_FLUSH
   } src_type;

   typedef struct packed {
      logic    accept;
      logic    load;
      src_type src;
      logic    last;
      logic    flush_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_activate;
      logic in_tag;
      logic in_stale;
      logic in_flush_empty;
      logic in_minus;
      logic minus_pending;
      logic out_free;
      logic remain_one;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ===== rtl/lrwb_ctrl.sv =====
// ---------------------------------------------------------------------------
// lrwb_ctrl
// Sequencer for tuple intake, result emission and activation flushes.
// ---------------------------------------------------------------------------
`default_nettype none

module lrwb_ctrl
   import lrwb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.accept     = 1'b0;
      cmd.load       = 1'b0;
      cmd.src        = SRC_PLUS;
      cmd.last       = 1'b0;
      cmd.flush_step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = !reset;
            cmd.accept = req_valid && !reset;
            if (req_valid) begin
               if (status.in_activate) begin
                  if (!status.in_stale && !status.in_flush_empty) begin
                     state_in = ST_FLUSH;
                  end
               end else if (status.in_tag) begin
                  state_in = ST_PLUS;
               end else if (status.in_minus) begin
                  state_in = ST_MINUS;
               end
            end
         end
         ST_PLUS: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.src  = SRC_PLUS;
               cmd.last = !status.minus_pending;
               state_in = status.minus_pending ? ST_MINUS : ST_IDLE;
            end
         end
         ST_MINUS: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.src  = SRC_MINUS;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.load       = 1'b1;
               cmd.src        = SRC_FLUSH;
               cmd.last       = status.remain_one;
               cmd.flush_step = 1'b1;
               if (status.remain_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/lrwb_datapath.sv =====
// ---------------------------------------------------------------------------
// lrwb_datapath
// Ring store, window bookkeeping, flush pointer and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module lrwb_datapath
   import lrwb_pkg::*;
#(
   parameter int STORE_DEPTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [WindowWidth-1:0] csr_write_data,
   input  wire req_type                req_data,
   output rsp_type                     rsp_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire ctrl_cmd_type           cmd,
   output ctrl_status_type             status
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = AW + 1;

   function automatic logic [AW-1:0] wrap_incr(input logic [AW-1:0] ptr);
      logic [AW-1:0] nxt;
      nxt = (ptr == AW'(STORE_DEPTH - 1)) ? '0 : ptr + AW'(1);
      return nxt;
   endfunction

   entry_type mem [STORE_DEPTH];

   logic [WindowWidth-1:0] window_ff;
   logic [AW-1:0]          oldest_ff, oldest_in;
   logic [AW-1:0]          tail_ff, tail_in;
   logic [CW-1:0]          occ_ff, occ_in;
   logic [CW-1:0]          buf_ff, buf_in;
   logic                   act_seen_ff, act_seen_in;
   logic [31:0]            act_time_ff, act_time_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [CW-1:0]          remain_ff, remain_in;
   logic                   minus_ff;
   req_type                item_ff;
   entry_type              rd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [CW-1:0] win_eff;
   logic          evict;
   logic          drop_old;
   logic          minus_now;
   logic          stale;
   logic [CW-1:0] low_cnt;
   logic [CW-1:0] cnt;
   logic [CW-1:0] tail_ext;
   logic [AW-1:0] start;
   logic          is_data;
   logic          wr_en;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     entry_in;

   always_comb begin
      win_eff   = (32'(window_ff) > 32'(STORE_DEPTH - 1)) ? CW'(STORE_DEPTH - 1)
                                                          : CW'(window_ff);
      evict     = occ_ff >= win_eff;
      drop_old  = evict && !req_data.master_tag && (buf_ff >= win_eff);
      minus_now = evict && !drop_old;
      stale     = act_seen_ff && (req_data.timestamp <= act_time_ff);
      low_cnt   = (buf_ff < occ_ff) ? buf_ff : occ_ff;
      cnt       = (32'(low_cnt) > 32'(MaxResults)) ? CW'(MaxResults) : low_cnt;
      tail_ext  = CW'(tail_ff);
      start     = (cnt > tail_ext) ? AW'(tail_ext + CW'(STORE_DEPTH) - cnt)
                                   : AW'(tail_ext - cnt);
      is_data   = req_data.command == CMD_DATA;

      entry_in.time_stamp = req_data.timestamp;
      entry_in.tag        = req_data.master_tag;
      entry_in.payload    = req_data.payload;

      wr_en   = cmd.accept && is_data;
      rd_en   = cmd.accept || cmd.flush_step;
      rd_addr = ptr_ff;
      if (cmd.accept) begin
         rd_addr = is_data ? oldest_ff : start;
      end
   end

   always_comb begin
      oldest_in   = oldest_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      buf_in      = buf_ff;
      act_seen_in = act_seen_ff;
      act_time_in = act_time_ff;
      ptr_in      = ptr_ff;
      remain_in   = remain_ff;
      if (cmd.accept) begin
         if (is_data) begin
            tail_in = wrap_incr(tail_ff);
            if (evict) begin
               oldest_in = wrap_incr(oldest_ff);
            end else begin
               occ_in = occ_ff + CW'(1);
            end
            if (!req_data.master_tag && !drop_old) begin
               buf_in = buf_ff + CW'(1);
            end
         end else if (!stale) begin
            act_seen_in = 1'b1;
            act_time_in = req_data.timestamp;
            buf_in      = '0;
            ptr_in      = wrap_incr(start);
            remain_in   = cnt;
         end
      end else if (cmd.flush_step) begin
         ptr_in    = wrap_incr(ptr_ff);
         remain_in = remain_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_in.last  = cmd.last;
         case (cmd.src)
            SRC_PLUS: begin
               rsp_in.mark        = MARK_PLUS;
               rsp_in.out_time    = item_ff.timestamp;
               rsp_in.out_tag     = item_ff.master_tag;
               rsp_in.out_payload = item_ff.payload;
            end
            SRC_MINUS: begin
               rsp_in.mark        = MARK_MINUS;
               rsp_in.out_time    = item_ff.timestamp;
               rsp_in.out_tag     = item_ff.master_tag;
               rsp_in.out_payload = rd_data_ff.payload;
            end
            SRC_FLUSH: begin
               rsp_in.mark        = MARK_PLUS;
               rsp_in.out_time    = rd_data_ff.time_stamp;
               rsp_in.out_tag     = rd_data_ff.tag;
               rsp_in.out_payload = rd_data_ff.payload;
            end
            default: begin
               rsp_in.mark        = MARK_PLUS;
               rsp_in.out_time    = rd_data_ff.time_stamp;
               rsp_in.out_tag     = rd_data_ff.tag;
               rsp_in.out_payload = rd_data_ff.payload;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WindowWidth'(1);
         oldest_ff    <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         buf_ff       <= '0;
         act_seen_ff  <= 1'b0;
         act_time_ff  <= '0;
         ptr_ff       <= '0;
         remain_ff    <= '0;
         minus_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_ff <= csr_write_data;
         end
         oldest_ff    <= oldest_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         buf_ff       <= buf_in;
         act_seen_ff  <= act_seen_in;
         act_time_ff  <= act_time_in;
         ptr_ff       <= ptr_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.accept) begin
            minus_ff <= minus_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= entry_in;
      end
      if (rd_en) begin
         rd_data_ff <= (wr_en && (rd_addr == tail_ff)) ? entry_in : mem[rd_addr];
      end
   end

   always_comb begin
      status.in_activate    = req_data.command == CMD_ACTIVATE;
      status.in_tag         = req_data.master_tag;
      status.in_stale       = stale;
      status.in_flush_empty = cnt == '0;
      status.in_minus       = minus_now;
      status.minus_pending  = minus_ff;
      status.out_free       = !rsp_valid_ff || rsp_ready;
      status.remain_one     = remain_ff == CW'(1);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/lazy_row_window_buffer.sv =====
// A data tuple's first result passes the state register and then the result register after
// acceptance; a flush's first result takes the same path after the activation is accepted.
// A data tuple with no result leaves the sequencer idle for the next request; one with results,
// and an activation that flushes entries, hold req_ready low until the last result is loaded.
// Reset is synchronous and active high; control state clears, the ring store does not.
// ---------------------------------------------------------------------------
// lazy_row_window_buffer
// Count-based sliding row window with lazy forwarding of buffered tuples.
// ---------------------------------------------------------------------------
`default_nettype none

module lazy_row_window_buffer
   import lrwb_pkg::*;
#(
   parameter int STORE_DEPTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write_enable,
   input  wire logic [WindowWidth-1:0] csr_write_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   lrwb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrwb_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

// ===== rtl/lrwb_checker.sv =====
// ---------------------------------------------------------------------------
// lrwb_checker
// Port-level checks on the row window buffer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lrwb_checker
   import lrwb_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   `ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   `ASSERT_IMPLY(busy_mid_item_a, clock, reset, rsp_valid && !rsp_data.last, !req_ready)

   `ASSERT_IMPLY(minus_is_last_a, clock, reset, rsp_valid && (rsp_data.mark == MARK_MINUS), rsp_data.last)

   `ASSERT_IMPLY(reset_clears_rsp_a, clock, reset, $past(reset), !rsp_valid)

endmodule

bind lazy_row_window_buffer lrwb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/tb_lazy_row_window_buffer.sv =====
// ---------------------------------------------------------------------------
// tb_lazy_row_window_buffer
// Drives data tuples and activation events into the row window buffer under
// random idling on both channels, predicts every plus and minus result from
// a behavioural copy of the window, and checks each result in order.
// ---------------------------------------------------------------------------
module tb_lazy_row_window_buffer;
   timeunit 1ns;
   timeprecision 1ps;

   import lrwb_pkg::*;

   localparam int unsigned DEPTH      = 64;
   localparam int unsigned SETTLE     = 100;
   localparam int unsigned HOLDOFF    = 400;
   localparam int unsigned CYCLE_CAP  = 1000000;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   req_type                req_data         = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [WindowWidth-1:0] csr_write_data   = '0;

   req_type     pending_req[$];
   rsp_type     expected_rsp[$];
   rsp_type     rsp_want;
   int unsigned items_queued     = 0;
   int unsigned items_taken      = 0;
   int unsigned error_count      = 0;
   int unsigned cycle_count      = 0;
   int unsigned req_gap_left     = 0;
   int unsigned rsp_stall_left   = 0;
   int unsigned holdoff_left     = 0;
   logic        req_fire         = 1'b0;
   logic        req_no_gaps      = 1'b0;
   logic        rsp_no_stalls    = 1'b0;
   logic        holdoff_request  = 1'b0;
   logic        holdoff_taken    = 1'b0;

   // window model
   logic [31:0]            win_payload[DEPTH];
   logic [31:0]            win_time[DEPTH];
   logic                   win_tag[DEPTH];
   int unsigned            win_head   = 0;
   int unsigned            win_count  = 0;
   int unsigned            lazy_count = 0;
   logic                   act_valid  = 1'b0;
   logic [31:0]            act_stamp  = '0;
   logic [WindowWidth-1:0] win_size   = 6'd1;

   // stimulus-side activation time
   longint unsigned        gen_act    = 0;
   logic                   gen_act_any = 1'b0;

   lazy_row_window_buffer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 11) return 0;
      if (roll < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic predict_window(input req_type item);
      int unsigned limit;
      int unsigned slot;
      int unsigned flush_n;
      int unsigned start;
      int unsigned idx;
      logic [31:0] evicted;
      rsp_type     batch[$];
      rsp_type     r;
      limit = (win_size > DEPTH - 1) ? DEPTH - 1 : win_size;
      if (item.command == CMD_ACTIVATE) begin
         if (!(act_valid && item.timestamp <= act_stamp)) begin
            act_valid = 1'b1;
            act_stamp = item.timestamp;
            flush_n = lazy_count;
            if (flush_n > win_count) flush_n = win_count;
            if (flush_n > MaxResults) flush_n = MaxResults;
            start = (win_head + win_count + DEPTH - flush_n) % DEPTH;
            for (int unsigned i = 0; i < flush_n; i++) begin
               idx = (start + i) % DEPTH;
               r = '{MARK_PLUS, win_time[idx], win_tag[idx], win_payload[idx], 1'b0};
               batch.insert(batch.size(), r);
            end
            lazy_count = 0;
         end
      end else begin
         slot = (win_head + win_count) % DEPTH;
         win_payload[slot] = item.payload;
         win_time[slot]    = item.timestamp;
         win_tag[slot]     = item.master_tag;
         win_count++;
         if (item.master_tag) begin
            r = '{MARK_PLUS, item.timestamp, item.master_tag, item.payload, 1'b0};
            batch.insert(batch.size(), r);
         end else begin
            lazy_count++;
         end
         if (win_count > limit) begin
            evicted  = win_payload[win_head];
            win_head = (win_head + 1) % DEPTH;
            win_count--;
            if (!item.master_tag && lazy_count > limit) begin
               lazy_count--;
            end else begin
               r = '{MARK_MINUS, item.timestamp, item.master_tag, evicted, 1'b0};
               batch.insert(batch.size(), r);
            end
         end
      end
      foreach (batch[i]) begin
         r = batch[i];
         r.last = (i == batch.size() - 1);
         expected_rsp.insert(expected_rsp.size(), r);
      end
   endtask

   // sample both channels
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_window(req_data);
            items_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding: %h", rsp_data));
            end else begin
               rsp_want = expected_rsp.pop_front();
               if (rsp_data.mark !== rsp_want.mark)
                  report_mismatch($sformatf("mark %b, want %b",
                                            rsp_data.mark, rsp_want.mark));
               if (rsp_data.out_time !== rsp_want.out_time)
                  report_mismatch($sformatf("out_time %h, want %h",
                                            rsp_data.out_time, rsp_want.out_time));
               if (rsp_data.out_tag !== rsp_want.out_tag)
                  report_mismatch($sformatf("out_tag %b, want %b",
                                            rsp_data.out_tag, rsp_want.out_tag));
               if (rsp_data.out_payload !== rsp_want.out_payload)
                  report_mismatch($sformatf("out_payload %h, want %h",
                                            rsp_data.out_payload, rsp_want.out_payload));
               if (rsp_data.last !== rsp_want.last)
                  report_mismatch($sformatf("last %b, want %b",
                                            rsp_data.last, rsp_want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("FAIL");
         $finish;
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold until the transaction is taken
      end else if (req_gap_left > 0) begin
         req_valid    <= 1'b0;
         req_gap_left <= req_gap_left - 1;
      end else if (pending_req.size() > 0) begin
         req_data     <= pending_req.pop_front();
         req_valid    <= 1'b1;
         req_gap_left <= req_no_gaps ? 0 : pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_request && !holdoff_taken) begin
         holdoff_taken <= 1'b1;
         holdoff_left  <= HOLDOFF;
         rsp_ready     <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_ready    <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_no_stalls && $urandom_range(0, 3) == 0)
            rsp_stall_left <= pick_gap();
      end
   end

   task automatic queue_tuple(input logic tag, input logic [31:0] ts, input logic [31:0] pay);
      req_type item;
      item = '{CMD_DATA, ts, tag, pay};
      pending_req.insert(pending_req.size(), item);
      items_queued++;
   endtask

   task automatic queue_activation(input logic [31:0] ts);
      req_type item;
      item = '{CMD_ACTIVATE, ts, 1'($urandom_range(0, 1)), $urandom};
      pending_req.insert(pending_req.size(), item);
      items_queued++;
   endtask

   task automatic queue_fresh_activation();
      gen_act     = gen_act_any ? gen_act + longint'($urandom_range(1, 1 << 25))
                                : longint'($urandom_range(0, 3));
      gen_act_any = 1'b1;
      queue_activation(gen_act[31:0]);
   endtask

   task automatic drain();
      while (items_taken != items_queued || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_window(input logic [WindowWidth-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      win_size = value;
   endtask

   task automatic random_phase(input int unsigned n);
      int unsigned done;
      int unsigned pick;
      int unsigned burst;
      done = 0;
      while (done < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            burst = $urandom_range(1, 8);
            repeat (burst) queue_tuple(1'b0, $urandom, $urandom);
            queue_fresh_activation();
            done += burst + 1;
         end else if (pick < 50) begin
            queue_tuple(1'b0, $urandom, $urandom);
            done++;
         end else if (pick < 80) begin
            queue_tuple(1'b1, $urandom, $urandom);
            done++;
         end else if (pick < 90 || !gen_act_any) begin
            queue_fresh_activation();
            done++;
         end else begin
            queue_activation(gen_act[31:0]
                             - $urandom_range(0, 32'((gen_act > 100) ? 100 : gen_act)));
            done++;
         end
      end
   endtask

   initial begin
      logic [WindowWidth-1:0] sizes[9];
      sizes = '{6'd63, 6'd5, 6'd1, 6'd0, 6'd17, 6'd32, 6'd2, 6'd9, 6'd63};

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // default window of one
      queue_activation(32'h0000_0000);
      queue_activation(32'h0000_0000);
      queue_tuple(1'b1, 32'h0000_0000, 32'h0000_0000);
      queue_tuple(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_tuple(1'b0, 32'h0000_0007, 32'hA5A5_A5A5);
      queue_tuple(1'b0, 32'h0000_0008, 32'h5A5A_5A5A);
      queue_activation(32'h0000_000A);
      queue_activation(32'h0000_0009);
      gen_act     = 10;
      gen_act_any = 1'b1;
      drain();

      write_window(6'd0);
      queue_tuple(1'b1, 32'h0000_0014, 32'h0000_0001);
      queue_tuple(1'b1, 32'h0000_0015, 32'h8000_0000);
      queue_tuple(1'b0, 32'h0000_0016, 32'h7FFF_FFFF);
      queue_fresh_activation();
      drain();

      write_window(6'd63);
      queue_tuple(1'b0, 32'h0000_0020, 32'h0000_0020);
      queue_tuple(1'b0, 32'h0000_0021, 32'h0000_0021);
      queue_tuple(1'b1, 32'h0000_0022, 32'h0000_0022);
      queue_tuple(1'b0, 32'h0000_0023, 32'h0000_0023);
      queue_tuple(1'b1, 32'h0000_0024, 32'h0000_0024);
      queue_fresh_activation();
      drain();

      // shrink below the current occupancy
      write_window(6'd2);
      queue_tuple(1'b0, 32'h0000_0030, 32'h0000_0030);
      queue_tuple(1'b1, 32'h0000_0031, 32'h0000_0031);
      queue_tuple(1'b0, 32'h0000_0032, 32'h0000_0032);
      queue_fresh_activation();
      drain();

      foreach (sizes[i]) begin
         req_no_gaps   = (i % 3 == 1);
         rsp_no_stalls = (i % 3 == 2);
         write_window(sizes[i]);
         random_phase(8);
         drain();
      end

      // feed tuples into the widest window while results are held back
      req_no_gaps   = 1'b1;
      rsp_no_stalls = 1'b0;
      write_window(6'd63);
      holdoff_request = 1'b1;
      repeat (14) queue_tuple(1'b1, $urandom, $urandom);
      repeat (6) queue_tuple(1'b0, $urandom, $urandom);
      queue_fresh_activation();
      repeat (4) queue_tuple(1'b1, $urandom, $urandom);
      queue_activation(32'hFFFF_FFFF);
      drain();

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lrwb_pkg.sv
rtl/lrwb_ctrl.sv
rtl/lrwb_datapath.sv
rtl/lazy_row_window_buffer.sv
rtl/lrwb_checker.sv
tb/tb_lazy_row_window_buffer.sv
